// File: src/rtp_pkg.sv
// Shared types, character codes and digit decode for the radix integer text parser.
package rtp_pkg;

	// One input word: a byte of text and its end-of-string mark
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_word_t;

	// One result word
	typedef struct packed {
		logic signed [63:0] value;
		logic               is_nan;
		logic               saturated;
	} result_word_t;

	// Parse phase
	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGN,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	localparam logic [63:0] LIMIT_MAG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [5:0] RADIX_DEFAULT = 6'd10;
	localparam logic [5:0] RADIX_MIN     = 6'd2;
	localparam logic [5:0] RADIX_MAX     = 6'd36;
	localparam logic [5:0] RADIX_HEX     = 6'd16;
	localparam logic [5:0] NOT_DIGIT     = 6'd63;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	// Decode a byte into its digit value, NOT_DIGIT for anything else
	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			return d[5:0];
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A + 8'd10;
			return d[5:0];
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A + 8'd10;
			return d[5:0];
		end
		return NOT_DIGIT;
	endfunction

endpackage

// File: src/radix_integer_text_parser_unit.sv
// Top level of the radix integer text parser: input stage, parse state and result register.
//
// Usage:
//   Text enters on the src channel one byte per word (src_word.char_code), with
//   src_word.last_char set on the final byte of a string. A word moves when
//   src_valid is high and src_stall is low. One result word per string leaves
//   on the res channel (res_valid / res_stall) after its last byte: the signed
//   value, is_nan (no digit parsed or radix invalid) and saturated (the
//   magnitude left the signed 64-bit range). Bytes that are not last give no
//   result. The user must write the base on cfg (cfg_valid / cfg_ready,
//   always ready) only while no string is in flight; the block itself does
//   not enforce it. 0 selects base 10. Throughput: one byte per cycle while
//   src_stall is low; the per-byte multiply-add by the radix and its overflow
//   compare form the single stage between input and result registers, and the
//   parse state feeds back into it on each byte that advances.
//   Reset clears the parse state, the radix (base 10) and both valid flags.
//   A stalled result holds in the result register; further non-last bytes
//   keep flowing, and src_stall rises only when a last byte finds the result
//   register full and stalled.
module radix_integer_text_parser_unit
	import rtp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_radix,
	input  logic         src_valid,
	output logic         src_stall,
	input  char_word_t   src_word,
	output logic         res_valid,
	input  logic         res_stall,
	output result_word_t res_word
);

	logic [5:0]   radix_q;
	logic         valid_s1;
	char_word_t   word_s1;
	phase_t       phase_q;
	logic [63:0]  mag_q;
	logic         neg_q;
	logic         ovf_q;
	logic         seen_q;
	logic         res_valid_q;
	result_word_t res_word_q;

	logic         out_free;
	logic         advance;
	logic         r_ok;
	logic [5:0]   r_val;
	logic [7:0]   c;
	logic [5:0]   dig;
	logic         is_digit;
	logic         is_ws;
	logic         is_sign;
	logic         is_x;
	phase_t       after_sign;
	phase_t       phase_d;
	logic         acc_en;
	logic         neg_d;
	logic [69:0]  prod;
	logic [63:0]  mag_d;
	logic         ovf_d;
	logic         seen_d;
	result_word_t res_d;

	// Config port: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= 6'd0;
		end else if (cfg_valid) begin
			radix_q <= cfg_radix;
		end
	end

	// Handshake: advance the input stage unless a last byte meets a blocked result
	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && (!word_s1.last_char || out_free);
	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			word_s1 <= src_word;
		end
	end

	// Decode radix and byte
	always_comb begin
		r_ok  = 1'b0;
		r_val = RADIX_DEFAULT;
		if (radix_q == 6'd0) begin
			r_ok = 1'b1;
		end else if (radix_q inside {[RADIX_MIN:RADIX_MAX]}) begin
			r_ok  = 1'b1;
			r_val = radix_q;
		end
	end

	assign c        = word_s1.char_code;
	assign dig      = digit_value(c);
	assign is_digit = r_ok && (dig < r_val);
	assign is_ws    = (c inside {[CH_TAB:CH_CR]}) || (c == CH_SPACE);
	assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
	assign is_x     = (c == CH_LO_X) || (c == CH_UP_X);

	// Phase after the first byte past the sign position
	always_comb begin
		if (!is_digit) begin
			after_sign = PH_DONE;
		end else if (dig == 6'd0 && r_val == RADIX_HEX) begin
			after_sign = PH_ZERO;
		end else begin
			after_sign = PH_DIGITS;
		end
	end

	// Next phase
	always_comb begin
		case (phase_q)
			PH_SKIP: begin
				if (is_ws) begin
					phase_d = PH_SKIP;
				end else if (is_sign) begin
					phase_d = PH_SIGN;
				end else begin
					phase_d = after_sign;
				end
			end
			PH_SIGN: begin
				phase_d = after_sign;
			end
			PH_ZERO: begin
				if (is_x) begin
					phase_d = PH_PREFIX;
				end else if (!is_digit) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_DIGITS;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				phase_d = is_digit ? PH_DIGITS : PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	// Phase outputs: digit take and sign capture
	always_comb begin
		acc_en = 1'b0;
		neg_d  = neg_q;
		case (phase_q)
			PH_SKIP: begin
				if (is_sign) begin
					neg_d = (c == CH_MINUS);
				end else if (!is_ws) begin
					acc_en = is_digit;
				end
			end
			PH_SIGN, PH_PREFIX, PH_DIGITS: begin
				acc_en = is_digit;
			end
			PH_ZERO: begin
				acc_en = is_digit && !is_x;
			end
			default: begin
				acc_en = 1'b0;
			end
		endcase
	end

	// Multiply-add by the radix; overflow when the new magnitude passes 2^63
	assign prod = 70'(mag_q) * 70'(r_val) + 70'(dig);

	always_comb begin
		mag_d  = mag_q;
		ovf_d  = ovf_q;
		seen_d = seen_q;
		if (acc_en) begin
			seen_d = 1'b1;
			if (!ovf_q) begin
				if (prod > 70'(LIMIT_MAG)) begin
					ovf_d = 1'b1;
				end else begin
					mag_d = prod[63:0];
				end
			end
		end
	end

	// Form the result word from the updated state
	always_comb begin
		res_d.value     = '0;
		res_d.is_nan    = 1'b0;
		res_d.saturated = 1'b0;
		if (!r_ok || !seen_d) begin
			res_d.is_nan = 1'b1;
		end else if (neg_d) begin
			if (ovf_d) begin
				res_d.value     = $signed(LIMIT_MAG);
				res_d.saturated = 1'b1;
			end else begin
				res_d.value = $signed(64'd0 - mag_d);
			end
		end else begin
			if (ovf_d || mag_d > MAX_POS) begin
				res_d.value     = $signed(MAX_POS);
				res_d.saturated = 1'b1;
			end else begin
				res_d.value = $signed(mag_d);
			end
		end
	end

	// Parse state: update per byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			if (word_s1.last_char) begin
				phase_q <= PH_SKIP;
				mag_q   <= '0;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				ovf_q   <= ovf_d;
				seen_q  <= seen_d;
			end
		end
	end

	// Result register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && word_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_char) begin
			res_word_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// Checks
	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q <= LIMIT_MAG)
		else $error("magnitude above 2^63");

	a_nan_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_word_q.is_nan |-> res_word_q.value == '0 && !res_word_q.saturated)
		else $error("NaN result carries value or saturation");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_word_q.saturated |->
			(res_word_q.value == $signed(MAX_POS) || res_word_q.value == $signed(LIMIT_MAG)))
		else $error("saturated result not at an extreme");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && word_s1.last_char && res_valid_q && res_stall)
		else $error("input stalled without a blocked result");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last_char |=> phase_q == PH_SKIP && !seen_q)
		else $error("parse state not cleared after last byte");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the radix integer text parser: random strings, radix phases, stalls.
`timescale 1ns / 1ps

import rtp_pkg::*;

// Track the parse of each string and hold the values it must produce
class parse_board;
	localparam int unsigned NO_DIGIT = 99;

	logic [5:0]   radix;
	phase_t       phase;
	logic [63:0]  magnitude;
	bit           negative;
	bit           overflowed;
	bit           digit_seen;
	result_word_t pending_results[$];
	int unsigned  faults;

	function new();
		radix = '0;
		faults = 0;
		clear_parse();
	endfunction

	function void clear_parse();
		phase = PH_SKIP;
		magnitude = '0;
		negative = 1'b0;
		overflowed = 1'b0;
		digit_seen = 1'b0;
	endfunction

	// Base in force, 0 when the register holds an invalid base
	function int unsigned base_of();
		if (radix == '0)
			return 10;
		if (radix >= RADIX_MIN && radix <= RADIX_MAX)
			return 32'(radix);
		return 0;
	endfunction

	function int unsigned digit_of(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return 32'(c - CH_0);
		if (c >= CH_LO_A && c <= CH_LO_Z)
			return c - CH_LO_A + 10;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			return c - CH_UP_A + 10;
		return NO_DIGIT;
	endfunction

	// Multiply-add one digit, latch overflow once the magnitude passes 2^63
	function void add_digit(int unsigned d, int unsigned r);
		logic [63:0] bound;
		digit_seen = 1'b1;
		if (overflowed)
			return;
		bound = (LIMIT_MAG - 64'(d)) / 64'(r);
		if (magnitude > bound) begin
			overflowed = 1'b1;
			return;
		end
		magnitude = magnitude * 64'(r) + 64'(d);
	endfunction

	function void take_byte(logic [7:0] c);
		int unsigned r;
		int unsigned d;
		bit          digit;
		r = base_of();
		d = digit_of(c);
		digit = (r != 0) && (d < r);
		// Skip whitespace, take an optional sign, otherwise fall into the sign phase
		if (phase == PH_SKIP) begin
			if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				negative = (c == CH_MINUS);
				phase = PH_SIGN;
				return;
			end
			phase = PH_SIGN;
		end
		case (phase)
			PH_SIGN: begin
				if (!digit) begin
					phase = PH_DONE;
					return;
				end
				add_digit(d, r);
				phase = (d == 0 && r == RADIX_HEX) ? PH_ZERO : PH_DIGITS;
			end
			PH_ZERO: begin
				if (c == CH_LO_X || c == CH_UP_X) begin
					phase = PH_PREFIX;
					return;
				end
				if (!digit) begin
					phase = PH_DONE;
					return;
				end
				add_digit(d, r);
				phase = PH_DIGITS;
			end
			PH_PREFIX, PH_DIGITS: begin
				if (!digit) begin
					phase = PH_DONE;
					return;
				end
				add_digit(d, r);
				phase = PH_DIGITS;
			end
			default: ;
		endcase
	endfunction

	// Note one accepted input word; a last byte queues the value of the string
	function void note_char(char_word_t w);
		result_word_t res;
		take_byte(w.char_code);
		if (!w.last_char)
			return;
		res = '0;
		if (base_of() == 0 || !digit_seen) begin
			res.is_nan = 1'b1;
		end else if (negative) begin
			if (overflowed) begin
				res.value = LIMIT_MAG;
				res.saturated = 1'b1;
			end else begin
				res.value = 64'd0 - magnitude;
			end
		end else if (overflowed || magnitude > MAX_POS) begin
			res.value = MAX_POS;
			res.saturated = 1'b1;
		end else begin
			res.value = magnitude;
		end
		pending_results.push_back(res);
		clear_parse();
	endfunction

	// Compare one accepted result word with the oldest pending value
	function void check_result(result_word_t got);
		result_word_t want;
		if (pending_results.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("unexpected result word: value %0d is_nan %b saturated %b",
					got.value, got.is_nan, got.saturated);
			return;
		end
		want = pending_results.pop_front();
		if (got.value !== want.value || got.is_nan !== want.is_nan ||
				got.saturated !== want.saturated) begin
			faults++;
			if (faults <= 10)
				$display("mismatch: expected value %0d is_nan %b saturated %b, got %0d %b %b",
					want.value, want.is_nan, want.saturated,
					got.value, got.is_nan, got.saturated);
		end
	endfunction
endclass

module testbench;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam logic [5:0]  RADIX_BAD    = 6'd1;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [5:0]   cfg_radix;
	logic         src_valid;
	logic         src_stall;
	char_word_t   src_word;
	logic         res_valid;
	logic         res_stall;
	result_word_t res_word;

	parse_board   board;
	logic [7:0]   text_q[$];
	int unsigned  items_sent = 0;
	int unsigned  idle_cycles = 0;
	bit           tx_calm;
	bit           rx_calm;

	radix_integer_text_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_radix (cfg_radix),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// End the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic int unsigned draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [7:0] digit_char(int unsigned d);
		if (d < 10)
			return CH_0 + 8'(d);
		if ($urandom_range(0, 1))
			return CH_LO_A + 8'(d - 10);
		return CH_UP_A + 8'(d - 10);
	endfunction

	function automatic logic [7:0] pick_space();
		if ($urandom_range(0, 5) == 0)
			return CH_SPACE;
		return CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	// Send one byte after a random gap, hold it until accepted
	task automatic send_char(logic [7:0] c, bit last);
		char_word_t  w;
		int unsigned gap;
		w.char_code = c;
		w.last_char = last;
		gap = draw_wait(tx_calm);
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= w;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		board.note_char(w);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_queue();
		foreach (text_q[i])
			send_char(text_q[i], i == text_q.size() - 1);
	endtask

	// Drop valid and wait until every pending value has come out
	task automatic wait_idle();
		src_valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(logic [5:0] r);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_radix <= r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.radix = r;
	endtask

	// Build one string: mostly well-formed numbers, some noise and range edges
	task automatic fill_text();
		int unsigned kind;
		int unsigned r;
		int unsigned n;
		logic [63:0] mag;
		logic [7:0]  digits[$];
		text_q.delete();
		r = board.base_of();
		kind = $urandom_range(0, 19);
		if (kind < 4) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) text_q.push_back(pick_space());
		case ($urandom_range(0, 3))
			0: text_q.push_back(CH_MINUS);
			1: text_q.push_back(CH_PLUS);
			default: ;
		endcase
		if ($urandom_range(0, 15) == 0)
			text_q.push_back(pick_space());
		if ((r == RADIX_HEX && $urandom_range(0, 2) == 0) || $urandom_range(0, 15) == 0) begin
			text_q.push_back(CH_0);
			text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
		end
		if (kind < 6) begin
			// Render a magnitude at the edge of the signed 64-bit range
			if (r == 0)
				r = 10;
			case ($urandom_range(0, 3))
				0: mag = MAX_POS;
				1: mag = LIMIT_MAG;
				2: mag = LIMIT_MAG + 64'd1;
				default: mag = '1;
			endcase
			do begin
				digits.push_front(digit_char(32'(mag % r)));
				mag = mag / r;
			end while (mag != 0);
			text_q = {text_q, digits};
		end else begin
			if (r == 0)
				r = 36;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 66) : $urandom_range(0, 6);
			repeat (n) text_q.push_back(digit_char($urandom_range(0, r - 1)));
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
		if (text_q.size() == 0)
			text_q.push_back(CH_SPACE);
	endtask

	// Take result words with random stalls
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(rx_calm);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			board.check_result(res_word);
		end
	end

	initial begin
		logic [5:0]  radix_plan[9];
		logic [5:0]  r;
		int unsigned p;
		int unsigned phase_end;
		radix_plan = '{6'd0, 6'd2, 6'd36, 6'd1, 6'd16, 6'd37, 6'd63, 6'd10, 6'd8};
		board = new();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_radix <= '0;
		src_valid <= 1'b0;
		src_word <= '0;
		res_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, sign and whitespace cases, hex prefix, bad base, base 36
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_text(" \t+7z");
		send_text("-");
		send_text("- 4");
		write_radix(RADIX_HEX);
		send_text("0x");
		send_text("-0XfF");
		send_text("0");
		write_radix(RADIX_BAD);
		send_text("5");
		write_radix(RADIX_MAX);
		send_text("Zz");

		// Random phases, each under its own base and idling mode
		items_sent = 0;
		p = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (p < 9)
				r = radix_plan[p];
			else if ($urandom_range(0, 3) == 0)
				r = 6'($urandom_range(0, 63));
			else
				r = 6'($urandom_range(2, 36));
			p++;
			write_radix(r);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			phase_end = items_sent + $urandom_range(40, 120);
			while (items_sent < phase_end) begin
				fill_text();
				send_queue();
			end
		end

		wait_idle();
		if (board.faults == 0 && board.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
